### sv/fup_pkg.sv
// ----------------------------------------------------------------------------
// fup_pkg
// Shared types for the form urlencoded parser: channel payloads, the run of
// results that one input item produces, and the result kind codes.
// ----------------------------------------------------------------------------
package fup_pkg;

	// result kind codes
	localparam logic [1:0] KIND_KEY_BYTE   = 2'd0;
	localparam logic [1:0] KIND_VALUE_BYTE = 2'd1;
	localparam logic [1:0] KIND_END_KEY    = 2'd2;
	localparam logic [1:0] KIND_END_VALUE  = 2'd3;

	// most results one input item can produce
	localparam int unsigned RUN_MAX = 3;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_input;
	} in_item_t;

	typedef struct packed {
		logic [1:0] out_kind;
		logic [7:0] out_byte;
		logic       last_of_run;
	} out_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
	} slot_t;

	// all results of one input item, slot 0 first
	typedef struct packed {
		logic [1:0]          cnt;
		slot_t [RUN_MAX-1:0] slot;
	} run_t;

	// append one result to a run
	function automatic run_t run_put(input run_t r, input logic [1:0] kind,
		input logic [7:0] data);
		run_t o;
		o = r;
		if (r.cnt != 2'(RUN_MAX)) begin
			o.slot[r.cnt].kind = kind;
			o.slot[r.cnt].data = data;
			o.cnt = r.cnt + 2'd1;
		end
		return o;
	endfunction

endpackage

### sv/fup_front.sv
// ----------------------------------------------------------------------------
// fup_front
// Accepts request bytes, tracks key/value phase and escapes, and builds the
// run of decoded results for each byte combinationally, in the cycle it is taken.
// ----------------------------------------------------------------------------
module fup_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	input  logic [15:0]      cfg_data,
	input  logic             src_valid,
	output logic             src_ready,
	input  fup_pkg::in_item_t src_item,
	input  logic             q_full,
	output logic             q_wr,
	output fup_pkg::run_t    q_run
);
	import fup_pkg::*;

	localparam logic [7:0] CH_EQ      = 8'h3D;
	localparam logic [7:0] CH_AMP     = 8'h26;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_SPACE   = 8'h20;

	localparam logic [1:0] ESC_NONE = 2'd0;
	localparam logic [1:0] ESC_ONE  = 2'd1;
	localparam logic [1:0] ESC_TWO  = 2'd2;

	// {is_hex, value}
	function automatic logic [4:0] hex_decode(input logic [7:0] b);
		logic [4:0] r;
		r = 5'd0;
		if (b >= 8'h30 && b <= 8'h39) r = {1'b1, 4'(b - 8'h30)};
		else if (b >= 8'h61 && b <= 8'h66) r = {1'b1, 4'(b - 8'h57)};
		else if (b >= 8'h41 && b <= 8'h46) r = {1'b1, 4'(b - 8'h37)};
		return r;
	endfunction

	logic [15:0] max_len_q;
	logic [15:0] cnt_q, cnt_d;
	logic        phase_q, phase_d;
	logic        open_q, open_d;
	logic [1:0]  seen_q, seen_d;
	logic        fv_q, fv_d;
	logic [3:0]  ev_q, ev_d;
	logic        accept;
	run_t        run;
	logic [4:0]  hx;
	logic [1:0]  data_kind;
	logic [7:0]  delim;

	assign src_ready = !q_full;
	assign accept    = src_valid && src_ready;
	assign q_wr      = accept && (run.cnt != 2'd0);
	assign q_run     = run;

	// classify the byte and build its run
	always_comb begin
		run       = '0;
		cnt_d     = cnt_q;
		phase_d   = phase_q;
		open_d    = open_q;
		seen_d    = seen_q;
		fv_d      = fv_q;
		ev_d      = ev_q;
		hx        = hex_decode(src_item.in_byte);
		data_kind = phase_q ? KIND_VALUE_BYTE : KIND_KEY_BYTE;
		delim     = phase_q ? CH_AMP : CH_EQ;
		if (cnt_q < max_len_q) begin
			cnt_d = cnt_q + 16'd1;
			if (src_item.in_byte == delim) begin
				if (open_q) begin
					if (seen_q != ESC_NONE)
						run = run_put(run, data_kind,
							(seen_q == ESC_TWO && fv_q) ? {4'h0, ev_q} : 8'h00);
					seen_d  = ESC_NONE;
					fv_d    = 1'b0;
					ev_d    = 4'h0;
					run     = run_put(run, phase_q ? KIND_END_VALUE : KIND_END_KEY, 8'h00);
					open_d  = 1'b0;
					phase_d = !phase_q;
				end
			end else begin
				open_d = 1'b1;
				priority if (seen_q == ESC_ONE) begin
					fv_d   = hx[4];
					ev_d   = hx[3:0];
					seen_d = ESC_TWO;
				end else if (seen_q == ESC_TWO) begin
					run = run_put(run, data_kind,
						!fv_q ? 8'h00 : (hx[4] ? {ev_q, hx[3:0]} : {4'h0, ev_q}));
					seen_d = ESC_NONE;
					fv_d   = 1'b0;
					ev_d   = 4'h0;
				end else if (src_item.in_byte == CH_PERCENT) begin
					seen_d = ESC_ONE;
					fv_d   = 1'b0;
					ev_d   = 4'h0;
				end else if (src_item.in_byte == CH_PLUS) begin
					run = run_put(run, data_kind, CH_SPACE);
				end else begin
					run = run_put(run, data_kind, src_item.in_byte);
				end
			end
		end
		// end of input closes whatever is open
		if (src_item.end_of_input) begin
			if (phase_d || open_d) begin
				if (seen_d != ESC_NONE)
					run = run_put(run, phase_d ? KIND_VALUE_BYTE : KIND_KEY_BYTE,
						(seen_d == ESC_TWO && fv_d) ? {4'h0, ev_d} : 8'h00);
				if (!phase_d)
					run = run_put(run, KIND_END_KEY, 8'h00);
				run = run_put(run, KIND_END_VALUE, 8'h00);
			end
			cnt_d   = 16'd0;
			phase_d = 1'b0;
			open_d  = 1'b0;
			seen_d  = ESC_NONE;
			fv_d    = 1'b0;
			ev_d    = 4'h0;
		end
	end

	// parser state and length limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= 16'd1023;
			cnt_q     <= 16'd0;
			phase_q   <= 1'b0;
			open_q    <= 1'b0;
			seen_q    <= ESC_NONE;
			fv_q      <= 1'b0;
			ev_q      <= 4'h0;
		end else begin
			if (cfg_valid)
				max_len_q <= cfg_data;
			if (accept) begin
				cnt_q   <= cnt_d;
				phase_q <= phase_d;
				open_q  <= open_d;
				seen_q  <= seen_d;
				fv_q    <= fv_d;
				ev_q    <= ev_d;
			end
		end
	end

`ifndef SYNTH
	a_seen_range: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q != 2'd3)
		else $error("escape digit count out of range");
	a_eoi_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && src_item.end_of_input |=> cnt_q == 16'd0 && !phase_q && !open_q)
		else $error("end of input did not clear parser state");
	a_limit: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !src_item.end_of_input && cnt_q >= max_len_q |=> $stable(cnt_q))
		else $error("byte counted past length limit");
`endif

endmodule

### sv/fup_queue.sv
// ----------------------------------------------------------------------------
// fup_queue
// Short queue of result runs between the front and the back; each side
// stalls on its own.
// ----------------------------------------------------------------------------
module fup_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  fup_pkg::run_t wr_run,
	input  logic          rd_en,
	output fup_pkg::run_t rd_run,
	output logic          full,
	output logic          empty
);
	import fup_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	run_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full   = count_q == CNT_W'(DEPTH);
	assign empty  = count_q == '0;
	assign rd_run = mem_q[rd_ptr_q];

	// run storage
	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_ptr_q] <= wr_run;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (rd_en)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (wr_en && !rd_en)
				count_q <= count_q + 1'b1;
			else if (rd_en && !wr_en)
				count_q <= count_q - 1'b1;
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && full))
		else $error("write to full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_en && empty))
		else $error("read from empty queue");
	a_no_empty_run: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> wr_run.cnt != 2'd0)
		else $error("empty run written to queue");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && !rd_en |=> count_q == $past(count_q) + 1'b1)
		else $error("fill count did not follow write");
`endif

endmodule

### sv/fup_back.sv
// ----------------------------------------------------------------------------
// fup_back
// Takes runs from the queue head and sends their results one per cycle while
// dst_ready is high, marking the last result of each run.
// ----------------------------------------------------------------------------
module fup_back (
	input  logic                clk,
	input  logic                arst_n,
	input  fup_pkg::run_t       head_run,
	input  logic                q_empty,
	output logic                q_rd,
	output logic                dst_valid,
	input  logic                dst_ready,
	output fup_pkg::out_item_t  dst_item
);
	import fup_pkg::*;

	logic [1:0] idx_q;
	logic       last;
	slot_t      cur;

	assign cur       = head_run.slot[idx_q];
	assign last      = idx_q == (head_run.cnt - 2'd1);
	assign dst_valid = !q_empty;
	assign q_rd      = dst_valid && dst_ready && last;

	// result payload
	always_comb begin
		dst_item.out_kind    = cur.kind;
		dst_item.out_byte    = cur.data;
		dst_item.last_of_run = last;
	end

	// slot index within the head run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
		end else if (dst_valid && dst_ready) begin
			idx_q <= last ? 2'd0 : idx_q + 2'd1;
		end
	end

`ifndef SYNTH
	a_idx_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid |-> idx_q < head_run.cnt)
		else $error("slot index beyond run length");
	a_idx_rewind: assert property (@(posedge clk) disable iff (!arst_n)
		q_rd |=> idx_q == 2'd0)
		else $error("slot index not rewound after run");
	a_idx_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && !dst_ready |=> $stable(idx_q))
		else $error("slot index moved while stalled");
`endif

endmodule

### sv/form_urlencoded_parser_core.sv
// ----------------------------------------------------------------------------
// form_urlencoded_parser_core
// Decodes x-www-form-urlencoded request bytes into key and value bytes with
// end-of-key and end-of-value marks.
// ----------------------------------------------------------------------------
// flow: each taken item's run goes into the run queue and its results leave
//   from the queue head; one byte per cycle in while the queue is not full;
//   one result per cycle out while dst_ready is high; the queue absorbs bursts
// reset: parser state clears at once, length limit returns to 1023,
//   no clearing pass
module form_urlencoded_parser_core #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [15:0]        cfg_data,
	input  logic               src_valid,
	output logic               src_ready,
	input  fup_pkg::in_item_t  src_item,
	output logic               dst_valid,
	input  logic               dst_ready,
	output fup_pkg::out_item_t dst_item
);
	import fup_pkg::*;

	logic q_wr, q_rd, q_full, q_empty;
	run_t wr_run, head_run;

	assign cfg_ready = 1'b1;

	// front: accept and decode
	fup_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_item  (src_item),
		.q_full    (q_full),
		.q_wr      (q_wr),
		.q_run     (wr_run)
	);

	// run queue
	fup_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (q_wr),
		.wr_run (wr_run),
		.rd_en  (q_rd),
		.rd_run (head_run),
		.full   (q_full),
		.empty  (q_empty)
	);

	// back: serialize results
	fup_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_run  (head_run),
		.q_empty   (q_empty),
		.q_rd      (q_rd),
		.dst_valid (dst_valid),
		.dst_ready (dst_ready),
		.dst_item  (dst_item)
	);

endmodule

### verif/tb_form_urlencoded_parser_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_form_urlencoded_parser_core
// Self-checking bench for the form urlencoded parser. A queue-fed driver
// offers request bytes, a monitor predicts the decoded key/value items of
// each accepted byte and checks every result item in order. Runs through
// several length limits and idle patterns on both channels.
// ----------------------------------------------------------------------------
module tb_form_urlencoded_parser_core;
	import fup_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned SETTLE_CYCLES = 8;

	typedef enum int unsigned {
		IDLE_SRC_LIGHT,
		IDLE_DST_LIGHT,
		IDLE_NONE
	} idle_mode_t;

	typedef struct {
		in_item_t item;
		bit       drain_first;
	} pending_byte_t;

	logic      clk;
	logic      arst_n;
	logic      cfg_valid;
	logic      cfg_ready;
	logic [15:0] cfg_data;
	logic      src_valid;
	logic      src_ready;
	in_item_t  src_item;
	logic      dst_valid;
	logic      dst_ready;
	out_item_t dst_item;

	form_urlencoded_parser_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_item  (src_item),
		.dst_valid (dst_valid),
		.dst_ready (dst_ready),
		.dst_item  (dst_item)
	);

	// bench bookkeeping
	pending_byte_t pending_bytes[$];
	out_item_t     expected_results[$];
	out_item_t     step_results[$];
	logic [7:0]    request_bytes[$];
	int unsigned   mismatch_count = 0;
	int unsigned   src_idle_pct = 0;
	int unsigned   dst_idle_pct = 0;
	logic          src_taken = 1'b0;
	logic          cfg_taken = 1'b0;
	logic          drained_flag = 1'b0;

	// parser state as predicted
	logic        prs_value_phase = 1'b0;
	logic        prs_field_open = 1'b0;
	logic [1:0]  prs_esc_digits = 2'd0;
	logic        prs_esc_first_ok = 1'b0;
	logic [7:0]  prs_esc_value = 8'h00;
	logic [15:0] prs_byte_count = 16'd0;
	logic [15:0] prs_max_len = 16'd1023;

	// clock
	always #1 clk = ~clk;

	task automatic report_mismatch(input string what, input int unsigned got,
		input int unsigned want);
		$display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// hex digit decode
	function automatic logic hex_val(input logic [7:0] c, output logic [3:0] v);
		v = 4'h0;
		if (c >= "0" && c <= "9") begin
			v = 4'(c - "0");
			return 1'b1;
		end
		if (c >= "a" && c <= "f") begin
			v = 4'(c - "a" + 8'd10);
			return 1'b1;
		end
		if (c >= "A" && c <= "F") begin
			v = 4'(c - "A" + 8'd10);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void emit_result(input logic [1:0] kind, input logic [7:0] data);
		out_item_t o;
		if (step_results.size() < RUN_MAX) begin
			o.out_kind = kind;
			o.out_byte = data;
			o.last_of_run = 1'b0;
			step_results.push_back(o);
		end
	endfunction

	// pending escape gives out what it has decoded so far
	function automatic void flush_escape();
		if (prs_esc_digits != 2'd0)
			emit_result(prs_value_phase ? KIND_VALUE_BYTE : KIND_KEY_BYTE,
				(prs_esc_digits == 2'd2 && prs_esc_first_ok) ? prs_esc_value : 8'h00);
		prs_esc_digits = 2'd0;
		prs_esc_first_ok = 1'b0;
		prs_esc_value = 8'h00;
	endfunction

	// predict the result items of one accepted request byte
	function automatic void decode_request_byte(input in_item_t it);
		logic [7:0] b;
		logic [7:0] delim;
		logic [1:0] kind;
		logic [3:0] dv;
		logic [7:0] r;
		step_results.delete();
		b = it.in_byte;
		if (prs_byte_count < prs_max_len) begin
			prs_byte_count = prs_byte_count + 16'd1;
			delim = prs_value_phase ? "&" : "=";
			kind = prs_value_phase ? KIND_VALUE_BYTE : KIND_KEY_BYTE;
			if (b == delim) begin
				// leading delimiters are skipped, a closing one switches phase
				if (prs_field_open) begin
					flush_escape();
					emit_result(prs_value_phase ? KIND_END_VALUE : KIND_END_KEY, 8'h00);
					prs_field_open = 1'b0;
					prs_value_phase = ~prs_value_phase;
				end
			end else begin
				prs_field_open = 1'b1;
				if (prs_esc_digits == 2'd1) begin
					prs_esc_first_ok = hex_val(b, dv);
					prs_esc_value = {4'h0, dv};
					prs_esc_digits = 2'd2;
				end else if (prs_esc_digits == 2'd2) begin
					r = 8'h00;
					if (prs_esc_first_ok) begin
						r = prs_esc_value;
						if (hex_val(b, dv))
							r = {prs_esc_value[3:0], dv};
					end
					emit_result(kind, r);
					prs_esc_digits = 2'd0;
					prs_esc_first_ok = 1'b0;
					prs_esc_value = 8'h00;
				end else if (b == "%") begin
					prs_esc_digits = 2'd1;
					prs_esc_first_ok = 1'b0;
					prs_esc_value = 8'h00;
				end else if (b == "+") begin
					emit_result(kind, " ");
				end else begin
					emit_result(kind, b);
				end
			end
		end
		// end of request closes what is open and clears the parser
		if (it.end_of_input) begin
			if (prs_value_phase) begin
				flush_escape();
				emit_result(KIND_END_VALUE, 8'h00);
			end else if (prs_field_open) begin
				flush_escape();
				emit_result(KIND_END_KEY, 8'h00);
				emit_result(KIND_END_VALUE, 8'h00);
			end
			prs_value_phase = 1'b0;
			prs_field_open = 1'b0;
			prs_esc_digits = 2'd0;
			prs_esc_first_ok = 1'b0;
			prs_esc_value = 8'h00;
			prs_byte_count = 16'd0;
		end
		if (step_results.size() > 0)
			step_results[step_results.size() - 1].last_of_run = 1'b1;
		foreach (step_results[i])
			expected_results.push_back(step_results[i]);
	endfunction

	// monitor: check result items, predict on accepted bytes
	always @(posedge clk) begin : monitor
		out_item_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				prs_max_len = cfg_data;
			if (dst_valid && dst_ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result with none expected", dst_item, 0);
				end else begin
					want = expected_results.pop_front();
					if (dst_item.out_kind !== want.out_kind)
						report_mismatch("out_kind", dst_item.out_kind, want.out_kind);
					if (dst_item.out_byte !== want.out_byte)
						report_mismatch("out_byte", dst_item.out_byte, want.out_byte);
					if (dst_item.last_of_run !== want.last_of_run)
						report_mismatch("last_of_run", dst_item.last_of_run, want.last_of_run);
				end
			end
			if (src_valid && src_ready)
				decode_request_byte(src_item);
			src_taken <= src_valid && src_ready;
			cfg_taken <= cfg_valid && cfg_ready;
			drained_flag <= (pending_bytes.size() == 0) && !(src_valid && !src_ready)
				&& (expected_results.size() == 0);
		end
	end

	// driver: offer pending bytes, stall the result side
	always @(negedge clk) begin : driver
		logic          nv;
		in_item_t      ni;
		pending_byte_t s;
		if (arst_n) begin
			nv = src_valid;
			ni = src_item;
			if (src_valid && src_taken)
				nv = 1'b0;
			if (!nv && pending_bytes.size() > 0) begin
				if (pending_bytes[0].drain_first && expected_results.size() != 0) begin
					nv = 1'b0;
				end else if ($urandom_range(99) >= src_idle_pct) begin
					s = pending_bytes.pop_front();
					ni = s.item;
					nv = 1'b1;
				end
			end
			src_valid <= nv;
			src_item <= ni;
			dst_ready <= ($urandom_range(99) >= dst_idle_pct);
		end
	end

	// timeout
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("[form_urlencoded_parser_core] ERROR");
		$finish;
	end

	task automatic push_stim(input logic [7:0] b, input bit eoi, input bit drain);
		pending_byte_t p;
		p.item.in_byte = b;
		p.item.end_of_input = eoi;
		p.drain_first = drain;
		pending_bytes.push_back(p);
	endtask

	task automatic push_text(input string s, input bit eoi_last);
		for (int i = 0; i < s.len(); i++)
			push_stim(s[i], eoi_last && (i == s.len() - 1), 1'b0);
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
		if (v < 4'd10)
			return 8'("0") + 8'(v);
		return (upper ? 8'("A") : 8'("a")) + 8'(v) - 8'd10;
	endfunction

	// one piece of field content
	task automatic add_token();
		string plain;
		plain = "abcxyzAFGZ0189-._~*";
		case ($urandom_range(9))
			5: request_bytes.push_back("+");
			6, 7: begin
				request_bytes.push_back("%");
				request_bytes.push_back(hex_char(4'($urandom_range(15)),
					1'($urandom_range(1))));
				request_bytes.push_back(hex_char(4'($urandom_range(15)),
					1'($urandom_range(1))));
			end
			8: begin
				request_bytes.push_back("%");
				repeat ($urandom_range(1, 2))
					request_bytes.push_back(8'($urandom_range(255)));
			end
			9: request_bytes.push_back(8'($urandom_range(255)));
			default: request_bytes.push_back(plain[$urandom_range(plain.len() - 1)]);
		endcase
	endtask

	// one request: mostly key=value pairs, sometimes plain noise
	task automatic add_request();
		int unsigned n_pairs;
		string noise;
		bit drain;
		noise = "=&%+a";
		request_bytes.delete();
		drain = ($urandom_range(4) == 0);
		if ($urandom_range(5) == 0) begin
			repeat ($urandom_range(1, 12)) begin
				if ($urandom_range(1))
					request_bytes.push_back(8'($urandom_range(255)));
				else
					request_bytes.push_back(noise[$urandom_range(noise.len() - 1)]);
			end
		end else begin
			n_pairs = $urandom_range(1, 3);
			for (int p = 0; p < n_pairs; p++) begin
				if ($urandom_range(9) == 0)
					request_bytes.push_back("=");
				repeat ($urandom_range(1, 4)) add_token();
				request_bytes.push_back("=");
				if ($urandom_range(9) == 0)
					request_bytes.push_back("&");
				repeat ($urandom_range(0, 4)) add_token();
				if (p != n_pairs - 1 || $urandom_range(1))
					request_bytes.push_back("&");
			end
		end
		foreach (request_bytes[i])
			push_stim(request_bytes[i], i == request_bytes.size() - 1, drain && i == 0);
	endtask

	task automatic wait_drained();
		do @(negedge clk); while (!drained_flag);
	endtask

	// length limit write, only once the parser has gone quiet
	task automatic write_length_limit(input logic [15:0] value);
		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(negedge clk); while (!cfg_taken);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_idle(input idle_mode_t mode);
		case (mode)
			IDLE_SRC_LIGHT: begin
				src_idle_pct = 8;
				dst_idle_pct = 82;
			end
			IDLE_DST_LIGHT: begin
				src_idle_pct = 82;
				dst_idle_pct = 8;
			end
			default: begin
				src_idle_pct = 0;
				dst_idle_pct = 0;
			end
		endcase
	endtask

	task automatic run_phase(input logic [15:0] limit, input idle_mode_t mode,
		input int unsigned n_requests);
		write_length_limit(limit);
		set_idle(mode);
		@(negedge clk);
		repeat (n_requests) add_request();
	endtask

	// stimulus sequence
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 16'd0;
		src_valid = 1'b0;
		src_item = '0;
		dst_ready = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed requests at the reset length limit
		set_idle(IDLE_SRC_LIGHT);
		@(negedge clk);
		// skipped leading equals, ampersand as key data, escape, plus
		push_text("=&a%4A+", 1'b0);
		// escape cut by the delimiter before any digit
		push_text("%=", 1'b0);
		// skipped leading ampersand, equals as value data, bad first and second digit
		push_text("&=%zz%4z%4", 1'b0);
		// escape cut after one digit
		push_text("&", 1'b0);
		// zero and all-ones bytes, plus and percent taken as digits
		push_stim(8'h00, 1'b0, 1'b0);
		push_stim(8'hFF, 1'b0, 1'b0);
		push_text("%+%", 1'b0);
		// end of input with an open key and a pending escape
		push_text("%4", 1'b1);
		// end of input on an empty value, after a pause for all results
		push_stim("x", 1'b0, 1'b1);
		push_text("=&", 1'b1);
		repeat (2) add_request();

		run_phase(16'd0, IDLE_SRC_LIGHT, 1);
		run_phase(16'd65535, IDLE_DST_LIGHT, 2);
		run_phase(16'd6, IDLE_DST_LIGHT, 2);
		run_phase(16'd1, IDLE_NONE, 1);
		run_phase(16'd1023, IDLE_NONE, 2);

		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatch_count == 0)
			$display("[form_urlencoded_parser_core] OK");
		else
			$display("[form_urlencoded_parser_core] ERROR");
		$finish;
	end

endmodule

### filelist.f
sv/fup_pkg.sv
sv/fup_front.sv
sv/fup_queue.sv
sv/fup_back.sv
sv/form_urlencoded_parser_core.sv
verif/tb_form_urlencoded_parser_core.sv
